FILE: hw/rtl/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants for the contact square array generator
// Request payloads, configuration register indexes and datapath widths.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int CSA_MAX_PER_SIDE = 8;

    localparam int COORD_W    = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    // divisor: size + separation
    localparam int DIV_W      = CFG_DATA_W + 1;
    // extent: difference of two coordinates
    localparam int EXT_W      = COORD_W + 1;
    // numerator / running remainder: extent - 2*border + separation
    localparam int REM_W      = COORD_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] BORDER_RST = 16'd0;
    localparam logic [CFG_DATA_W-1:0] SIZE_RST   = 16'd1;
    localparam logic [CFG_DATA_W-1:0] SEP_RST    = 16'd0;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_bottom;
        logic signed [COORD_W-1:0] box_right;
        logic signed [COORD_W-1:0] box_top;
    } box_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sq_left;
        logic signed [COORD_W-1:0] sq_bottom;
        logic signed [COORD_W-1:0] sq_right;
        logic signed [COORD_W-1:0] sq_top;
        logic                      last_square;
    } sq_t;

    typedef struct packed {
        logic                    take;
        logic signed [REM_W-1:0] diff;
    } step_res_t;

endpackage

FILE: hw/rtl/contact_square_array_gen_top.sv
// ----------------------------------------------------------------------------
// contact_square_array_gen_top: contact square array generator
// Fills each rectangle request that fits a square with a centered grid of equal squares.
// ----------------------------------------------------------------------------
// Flow: an accepted rectangle goes through S_CHECK, S_DIVX and S_DIVY before
//   S_EMIT registers its first square. The per-axis counts come from one
//   shared subtract/compare unit, one step per cycle, then squares leave one
//   per cycle through the output register unless sq_ready stalls them; a new
//   rectangle is accepted only once the sequencer is back in S_IDLE.
// Reset: rst_n (async, active low) clears the sequencer and output valid and
//   loads border 0, size 1, separation 0.
module contact_square_array_gen_top
    import csa_pkg::*;
#(
    parameter int MAX_PER_SIDE = CSA_MAX_PER_SIDE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // rectangle requests
    input  logic                  box_valid,
    output logic                  box_ready,
    input  box_t                  box,
    // square requests
    output logic                  sq_valid,
    input  logic                  sq_ready,
    output sq_t                   sq
);

    localparam int CW = $clog2(MAX_PER_SIDE + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PER_SIDE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIVX,
        S_DIVY,
        S_EMIT
    } state_t;

    // configuration
    logic [CFG_DATA_W-1:0] border_reg, border_next;
    logic [CFG_DATA_W-1:0] size_reg, size_next;
    logic [CFG_DATA_W-1:0] sep_reg, sep_next;

    // sequencer
    state_t                  state_reg, state_next;
    logic signed [COORD_W-1:0] left_reg, left_next;
    logic signed [COORD_W-1:0] bottom_reg, bottom_next;
    logic signed [EXT_W-1:0]   w_reg, w_next;
    logic signed [EXT_W-1:0]   h_reg, h_next;
    logic [DIV_W-1:0]          d_reg, d_next;
    logic signed [REM_W-1:0]   rem_reg, rem_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [CW-1:0]             nx_reg, nx_next;
    logic [CW-1:0]             ny_reg, ny_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [CW-1:0]             j_reg, j_next;
    logic [COORD_W-1:0]        x0_reg, x0_next;
    logic [COORD_W-1:0]        x_reg, x_next;
    logic [COORD_W-1:0]        y_reg, y_next;

    // output register
    logic sq_valid_reg, sq_valid_next;
    sq_t  sq_reg, sq_next;

    // combinational helpers
    logic signed [EXT_W-1:0] size_ext;
    logic signed [REM_W-1:0] border2_ext;
    logic signed [REM_W-1:0] sep_ext;
    logic [DIV_W-1:0]        d_calc;
    logic [COORD_W-1:0]      start_off;
    logic                    out_free;
    logic                    last_x;
    logic                    last_y;
    step_res_t               step;

    csa_step u_step (
        .rem     (rem_reg),
        .divisor (d_reg),
        .res     (step)
    );

    assign size_ext    = $signed({{(EXT_W-CFG_DATA_W){1'b0}}, size_reg});
    assign border2_ext = $signed({{(REM_W-CFG_DATA_W-1){1'b0}}, border_reg, 1'b0});
    assign sep_ext     = $signed({{(REM_W-CFG_DATA_W){1'b0}}, sep_reg});
    assign d_calc      = {1'b0, size_reg} + {1'b0, sep_reg};
    // offset of the first square: border + leftover/2 (remainder is >= 0 here)
    assign start_off   = {{(COORD_W-CFG_DATA_W){1'b0}}, border_reg}
                       + rem_reg[COORD_W:1];
    assign out_free    = !sq_valid_reg || sq_ready;
    assign last_x      = (i_reg == nx_reg - CW'(1));
    assign last_y      = (j_reg == ny_reg - CW'(1));

    assign box_ready = (state_reg == S_IDLE);
    assign sq_valid  = sq_valid_reg;
    assign sq        = sq_reg;

    always_comb
    begin
        border_next   = border_reg;
        size_next     = size_reg;
        sep_next      = sep_reg;
        state_next    = state_reg;
        left_next     = left_reg;
        bottom_next   = bottom_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        d_next        = d_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        x0_next       = x0_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        sq_valid_next = sq_valid_reg;
        sq_next       = sq_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BORDER_WIDTH: border_next = cfg_data;
                CFG_SQUARE_SIZE:  size_next   = cfg_data;
                CFG_SEPARATION:   sep_next    = cfg_data;
                default:          ;
            endcase
        end

        if (sq_valid_reg && sq_ready)
            sq_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (box_valid)
                begin
                    left_next   = box.box_left;
                    bottom_next = box.box_bottom;
                    w_next      = EXT_W'(box.box_right) - EXT_W'(box.box_left);
                    h_next      = EXT_W'(box.box_top) - EXT_W'(box.box_bottom);
                    state_next  = S_CHECK;
                end
            end

            S_CHECK:
            begin
                d_next   = d_calc;
                cnt_next = '0;
                // x numerator: w - 2*border + sep
                rem_next = REM_W'(w_reg) - border2_ext + sep_ext;
                if (size_ext > w_reg || size_ext > h_reg || d_calc == '0)
                    state_next = S_IDLE;
                else
                    state_next = S_DIVX;
            end

            S_DIVX:
            begin
                if (step.take && cnt_reg < MAX_CNT)
                begin
                    rem_next = step.diff;
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (cnt_reg == '0)
                    state_next = S_IDLE;
                else
                begin
                    nx_next    = cnt_reg;
                    x0_next    = left_reg + start_off;
                    cnt_next   = '0;
                    rem_next   = REM_W'(h_reg) - border2_ext + sep_ext;
                    state_next = S_DIVY;
                end
            end

            S_DIVY:
            begin
                if (step.take && cnt_reg < MAX_CNT)
                begin
                    rem_next = step.diff;
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (cnt_reg == '0)
                    state_next = S_IDLE;
                else
                begin
                    ny_next    = cnt_reg;
                    y_next     = bottom_reg + start_off;
                    x_next     = x0_reg;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    sq_valid_next       = 1'b1;
                    sq_next.sq_left     = x_reg;
                    sq_next.sq_bottom   = y_reg;
                    sq_next.sq_right    = x_reg + {{(COORD_W-CFG_DATA_W){1'b0}}, size_reg};
                    sq_next.sq_top      = y_reg + {{(COORD_W-CFG_DATA_W){1'b0}}, size_reg};
                    sq_next.last_square = last_x && last_y;
                    if (last_x)
                    begin
                        i_next = '0;
                        j_next = j_reg + CW'(1);
                        x_next = x0_reg;
                        y_next = y_reg + {{(COORD_W-DIV_W){1'b0}}, d_reg};
                        if (last_y)
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + CW'(1);
                        x_next = x_reg + {{(COORD_W-DIV_W){1'b0}}, d_reg};
                    end
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg   <= BORDER_RST;
            size_reg     <= SIZE_RST;
            sep_reg      <= SEP_RST;
            state_reg    <= S_IDLE;
            left_reg     <= '0;
            bottom_reg   <= '0;
            w_reg        <= '0;
            h_reg        <= '0;
            d_reg        <= '0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
            nx_reg       <= '0;
            ny_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            x0_reg       <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            sq_valid_reg <= 1'b0;
            sq_reg       <= '0;
        end
        else
        begin
            border_reg   <= border_next;
            size_reg     <= size_next;
            sep_reg      <= sep_next;
            state_reg    <= state_next;
            left_reg     <= left_next;
            bottom_reg   <= bottom_next;
            w_reg        <= w_next;
            h_reg        <= h_next;
            d_reg        <= d_next;
            rem_reg      <= rem_next;
            cnt_reg      <= cnt_next;
            nx_reg       <= nx_next;
            ny_reg       <= ny_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            x0_reg       <= x0_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            sq_valid_reg <= sq_valid_next;
            sq_reg       <= sq_next;
        end
    end

`ifndef SYNTHESIS
    // accepted rectangle always goes to the fit check next
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && box_ready) |=> (state_reg == S_CHECK))
        else $error("accepted rectangle did not enter fit check");

    // count never passes the per-side limit
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= MAX_CNT))
        else $error("per-axis count above limit");

    // the shared unit never divides by zero
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVX || state_reg == S_DIVY) |-> (d_reg != '0))
        else $error("zero divisor in count loop");

    // grid indexes stay inside the grid while emitting
    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (i_reg < nx_reg && j_reg < ny_reg))
        else $error("emit index outside grid");
`endif

endmodule

FILE: hw/rtl/csa_step.sv
// ----------------------------------------------------------------------------
// csa_step: shared compare/subtract unit
// One trial subtraction of the divisor from the running remainder.
// ----------------------------------------------------------------------------
module csa_step
    import csa_pkg::*;
(
    input  logic signed [REM_W-1:0] rem,
    input  logic        [DIV_W-1:0] divisor,
    output step_res_t               res
);

    logic signed [REM_W-1:0] div_ext;

    assign div_ext  = $signed({{(REM_W-DIV_W){1'b0}}, divisor});
    assign res.diff = rem - div_ext;
    // negative remainder never takes
    assign res.take = (rem >= div_ext);

endmodule
